[src/rhc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSL conversion package
// Beat types, divider stage record and shared constants for the converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int COMP_W = 8;   // width of one color component
  localparam int HUE_W  = 9;   // hue in whole degrees
  localparam int REM_W  = 18;  // partial remainder of both dividers
  localparam int DEN_W  = 9;   // doubled divisor of both dividers
  localparam int QUO_W  = 9;   // quotient bits produced by the divider chain

  // Rounded hue that must wrap back to zero.
  localparam logic [HUE_W-1:0] HUE_FULL = 9'd360;

  // Which component holds the maximum.
  localparam logic [1:0] SECT_RED   = 2'd0;
  localparam logic [1:0] SECT_GREEN = 2'd1;
  localparam logic [1:0] SECT_BLUE  = 2'd2;

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [COMP_W-1:0] saturation;
    logic [COMP_W-1:0] lightness;
  } hsl_t;

  // State carried through the restoring divider stages.
  typedef struct packed {
    logic [REM_W-1:0]  hue_rem;
    logic [DEN_W-1:0]  hue_den;
    logic [QUO_W-1:0]  hue_q;
    logic [REM_W-1:0]  sat_rem;
    logic [DEN_W-1:0]  sat_den;
    logic [QUO_W-1:0]  sat_q;
    logic [COMP_W-1:0] lightness;
    logic              grey;
  } div_data_t;

endpackage

[src/rgb_to_hsl_convert.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSL converter
// Pipelined conversion of 8-bit RGB pixels into hue, saturation, lightness.
// ----------------------------------------------------------------------------
// Usage: a pixel beat enters on in_valid/in_data and is taken at a rising
// edge where in_valid is high and in_stall is low. One HSL beat leaves on
// out_valid/out_data for every pixel, in order, taken when out_stall is low.
// Hue is in whole degrees (0..359), saturation and lightness on 0..255.
//
// Twelve register stages: two front stages find the extremes and form the
// dividends, nine restoring stages produce one quotient bit each for both
// divisions, and an output register applies the grey and wrap cases.
// Throughput: one pixel per clock while out_stall stays low.
//
// Reset clears every stage valid bit; the block then accepts at once.
// When the receiver stalls, the held output beat stays unchanged and the
// stages behind it keep filling any empty slots; in_stall rises only once
// every stage holds a beat, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module rgb_to_hsl_convert (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  rhc_pkg::pixel_t in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output rhc_pkg::hsl_t   out_data
);

  localparam int NSTEP = rhc_pkg::QUO_W;

  // Handshake links between consecutive stages; index 0 leaves the front end.
  logic               vld [0:NSTEP];
  logic               stl [0:NSTEP];
  rhc_pkg::div_data_t dat [0:NSTEP];

  logic          out_valid_r;
  logic          stall_f;
  rhc_pkg::hsl_t out_r, out_nxt;

  rhc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .up_data  (in_data),
    .dn_valid (vld[0]),
    .dn_stall (stl[0]),
    .dn_data  (dat[0])
  );

  // The most significant quotient bit is resolved first.
  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    rhc_div_step #(
      .BIT (NSTEP - 1 - i)
    ) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld[i]),
      .up_stall (stl[i]),
      .up_data  (dat[i]),
      .dn_valid (vld[i+1]),
      .dn_stall (stl[i+1]),
      .dn_data  (dat[i+1])
    );
  end

  assign stall_f     = out_valid_r & out_stall;
  assign stl[NSTEP]  = stall_f;
  assign out_valid   = out_valid_r;
  assign out_data    = out_r;

  // A grey pixel has neither hue nor saturation; a hue rounded up to a full
  // turn wraps back to zero.
  always_comb begin
    out_nxt.lightness = dat[NSTEP].lightness;
    if (dat[NSTEP].grey) begin
      out_nxt.hue        = '0;
      out_nxt.saturation = '0;
    end else begin
      out_nxt.hue = (dat[NSTEP].hue_q >= rhc_pkg::HUE_FULL) ? '0 : dat[NSTEP].hue_q;
      out_nxt.saturation = dat[NSTEP].sat_q[rhc_pkg::COMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!stall_f) begin
      out_valid_r <= vld[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (!stall_f && vld[NSTEP]) out_r <= out_nxt;
  end

endmodule

[src/rhc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSL front end
// Two pipeline stages: extremes and lightness, then dividends and divisors.
// ----------------------------------------------------------------------------
module rhc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_stall,
  input  rhc_pkg::pixel_t    up_data,
  output logic               dn_valid,
  input  logic               dn_stall,
  output rhc_pkg::div_data_t dn_data
);

  typedef struct packed {
    logic signed [8:0] diff;
    logic [1:0]        sector;
    logic [7:0]        d;
    logic [8:0]        s;
    logic [7:0]        lit;
  } front_t;

  logic   va_r, vb_r;
  logic   stall_a, stall_b;
  front_t a_r, a_nxt;
  rhc_pkg::div_data_t b_r, b_nxt;

  assign stall_b  = vb_r & dn_stall;
  assign stall_a  = va_r & stall_b;
  assign up_stall = stall_a;
  assign dn_valid = vb_r;
  assign dn_data  = b_r;

  // Stage A: maximum, minimum, spread, sum and the sector difference.
  always_comb begin
    logic [7:0] mx, mn;
    logic [8:0] rr, gg, bb;
    mx = up_data.red;
    mn = up_data.red;
    rr = {1'b0, up_data.red};
    gg = {1'b0, up_data.green};
    bb = {1'b0, up_data.blue};
    if (up_data.green > mx) mx = up_data.green;
    if (up_data.blue > mx) mx = up_data.blue;
    if (up_data.green < mn) mn = up_data.green;
    if (up_data.blue < mn) mn = up_data.blue;
    a_nxt.d = mx - mn;
    a_nxt.s = {1'b0, mx} + {1'b0, mn};
    a_nxt.lit = 8'((a_nxt.s + 9'd1) >> 1);
    // Ties for the maximum go to blue first, then green.
    if (up_data.blue == mx) begin
      a_nxt.sector = rhc_pkg::SECT_BLUE;
      a_nxt.diff   = $signed(rr - gg);
    end else if (up_data.green == mx) begin
      a_nxt.sector = rhc_pkg::SECT_GREEN;
      a_nxt.diff   = $signed(bb - rr);
    end else begin
      a_nxt.sector = rhc_pkg::SECT_RED;
      a_nxt.diff   = $signed(gg - bb);
    end
  end

  // Stage B: hue dividend 2*num+d over 2*d, saturation 2*255*d+den over 2*den.
  always_comb begin
    logic signed [19:0] diff_x, d_x, num, num_pos, hue_n;
    logic [7:0]         den;
    logic [17:0]        sat_n;
    diff_x = {{11{a_r.diff[8]}}, a_r.diff};
    d_x    = {12'd0, a_r.d};
    case (a_r.sector)
      rhc_pkg::SECT_BLUE:  num = diff_x * 20'sd60 + d_x * 20'sd240;
      rhc_pkg::SECT_GREEN: num = diff_x * 20'sd60 + d_x * 20'sd120;
      default:             num = diff_x * 20'sd60;
    endcase
    num_pos = num[19] ? num + d_x * 20'sd360 : num;
    hue_n   = (num_pos <<< 1) + d_x;
    if (!a_r.s[8]) begin
      den = a_r.s[7:0];
    end else begin
      den = 8'(9'd510 - a_r.s);
    end
    sat_n = {10'd0, a_r.d} * 18'd510 + {10'd0, den};

    b_nxt.hue_rem   = hue_n[rhc_pkg::REM_W-1:0];
    b_nxt.hue_den   = {a_r.d, 1'b0};
    b_nxt.hue_q     = '0;
    b_nxt.sat_rem   = sat_n;
    b_nxt.sat_den   = {den, 1'b0};
    b_nxt.sat_q     = '0;
    b_nxt.lightness = a_r.lit;
    b_nxt.grey      = (a_r.d == 8'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (!stall_a) va_r <= up_valid;
      if (!stall_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall_a && up_valid) a_r <= a_nxt;
    if (!stall_b && va_r) b_r <= b_nxt;
  end

endmodule

[src/rhc_div_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSL divider stage
// One restoring step for the hue and the saturation quotients side by side.
// ----------------------------------------------------------------------------
module rhc_div_step #(
  parameter int BIT = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_stall,
  input  rhc_pkg::div_data_t up_data,
  output logic               dn_valid,
  input  logic               dn_stall,
  output rhc_pkg::div_data_t dn_data
);

  logic               v_r;
  logic               stall;
  rhc_pkg::div_data_t d_r, d_nxt;

  assign stall    = v_r & dn_stall;
  assign up_stall = stall;
  assign dn_valid = v_r;
  assign dn_data  = d_r;

  // Subtract the divisor at this bit's weight when it fits.
  always_comb begin
    logic [rhc_pkg::REM_W-1:0] hue_sh, sat_sh;
    hue_sh = rhc_pkg::REM_W'(up_data.hue_den) << BIT;
    sat_sh = rhc_pkg::REM_W'(up_data.sat_den) << BIT;
    d_nxt  = up_data;
    if (up_data.hue_rem >= hue_sh) begin
      d_nxt.hue_rem    = up_data.hue_rem - hue_sh;
      d_nxt.hue_q[BIT] = 1'b1;
    end
    if (up_data.sat_rem >= sat_sh) begin
      d_nxt.sat_rem    = up_data.sat_rem - sat_sh;
      d_nxt.sat_q[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (!stall) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall && up_valid) d_r <= d_nxt;
  end

endmodule
